// ===== hw/rtl/rmth_pkg.sv =====
// rmth_pkg: shared types for the running median block
// holds the cell operation code used by the sorted chains; no dependencies
package rmth_pkg;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_POP  = 2'd1,
    OP_INS  = 2'd2
  } op_t;

  typedef struct packed {
    op_t op;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/running_median_two_heaps.sv =====
// running_median_two_heaps: top level of the running lower-median block
// depends on rmth_pkg and rmth_chain (two sorted cell rows)
//
//  channel | ports                        | direction
//  --------+------------------------------+----------
//  in      | in_valid in_stall in_sample  | sample transaction in
//  out     | out_valid out_stall          | median transaction out
//          | out_median out_overflow      |
//
// an accepted sample passes a pop step, an insert step and the result load, set
// by the two shift steps of the cell rows; a dropped sample skips to the load
// reset is synchronous active low and empties both rows (fill counts only)
// in_stall is high while a sample is in work or its result cannot be loaded
// the result register lets the next sample in while out_stall holds a result
module running_median_two_heaps #(
  parameter int HEAP_DEPTH  = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_median,
  output logic                          out_overflow
);

  localparam int CW = $clog2(HEAP_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE, ST_POP, ST_INS, ST_DONE
  } state_t;

  state_t state_r;

  // lower half: max first, upper half: min first
  rmth_pkg::cell_ctl_t           lo_ctl, up_ctl;
  logic signed [SAMPLE_BITS-1:0] lo_x, up_x;
  logic signed [SAMPLE_BITS-1:0] lo_head, up_head;
  logic [CW-1:0]                 lo_cnt, up_cnt;

  // plan captured at accept
  logic                          lo_pop_r, up_pop_r, lo_ins_r, up_ins_r;
  logic signed [SAMPLE_BITS-1:0] lo_val_r, up_val_r;
  logic                          ovf_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_median_r;
  logic                          out_overflow_r;

  logic accept;
  logic balanced;
  logic full;
  logic out_free;

  assign accept   = in_valid && !in_stall;
  assign balanced = (lo_cnt == up_cnt);
  assign full     = balanced && (lo_cnt == CW'(HEAP_DEPTH));
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  rmth_chain #(
    .DEPTH(HEAP_DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .IS_MIN(1'b0), .CW(CW)
  ) u_lower (
    .clk(clk), .rst_n(rst_n), .ctl(lo_ctl), .x(lo_x),
    .head(lo_head), .count(lo_cnt)
  );

  rmth_chain #(
    .DEPTH(HEAP_DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .IS_MIN(1'b1), .CW(CW)
  ) u_upper (
    .clk(clk), .rst_n(rst_n), .ctl(up_ctl), .x(up_x),
    .head(up_head), .count(up_cnt)
  );

  // drive the rows from the captured plan
  always_comb begin
    lo_ctl.op = rmth_pkg::OP_NONE;
    up_ctl.op = rmth_pkg::OP_NONE;
    if (state_r == ST_POP) begin
      if (lo_pop_r) lo_ctl.op = rmth_pkg::OP_POP;
      if (up_pop_r) up_ctl.op = rmth_pkg::OP_POP;
    end else if (state_r == ST_INS) begin
      if (lo_ins_r) lo_ctl.op = rmth_pkg::OP_INS;
      if (up_ins_r) up_ctl.op = rmth_pkg::OP_INS;
    end
  end

  assign lo_x = lo_val_r;
  assign up_x = up_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lo_pop_r    <= 1'b0;
      up_pop_r    <= 1'b0;
      lo_ins_r    <= 1'b0;
      up_ins_r    <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      // in ST_DONE the result load decides out_valid_r instead
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            lo_pop_r <= 1'b0;
            up_pop_r <= 1'b0;
            lo_ins_r <= 1'b0;
            up_ins_r <= 1'b0;
            ovf_r    <= full;
            lo_val_r <= in_sample;
            up_val_r <= in_sample;
            if (full) begin
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_POP;
              if (balanced) begin
                // sample joins the lower half unless it beats the upper min
                lo_ins_r <= 1'b1;
                if (up_cnt != '0 && in_sample > up_head) begin
                  lo_val_r <= up_head;
                  up_pop_r <= 1'b1;
                  up_ins_r <= 1'b1;
                end
              end else begin
                // sample joins the upper half unless it is below the lower max
                up_ins_r <= 1'b1;
                if (in_sample < lo_head) begin
                  up_val_r <= lo_head;
                  lo_pop_r <= 1'b1;
                  lo_ins_r <= 1'b1;
                end
              end
            end
          end
        end
        ST_POP: state_r <= ST_INS;
        ST_INS: state_r <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_median_r   <= lo_head;
            out_overflow_r <= ovf_r;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_median   = out_median_r;
  assign out_overflow = out_overflow_r;

endmodule

// ===== hw/rtl/rmth_cell.sv =====
// rmth_cell: one slot of a sorted chain
// depends on rmth_pkg (cell_ctl_t); holds one sample, shifts with its neighbors
module rmth_cell #(
  parameter int IDX         = 0,
  parameter int SAMPLE_BITS = 16,
  parameter int CW          = 10,
  parameter bit IS_MIN      = 1'b0
) (
  input  logic                          clk,
  input  rmth_pkg::cell_ctl_t           ctl,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic [CW-1:0]                 count,
  input  logic signed [SAMPLE_BITS-1:0] prev_val,
  input  logic                          prev_keep,
  input  logic signed [SAMPLE_BITS-1:0] next_val,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic                          keep
);

  logic signed [SAMPLE_BITS-1:0] val_r;
  logic                          occupied;
  logic                          ahead;

  assign occupied = (CW'(IDX) < count);
  assign ahead    = IS_MIN ? (val_r <= x) : (val_r >= x);
  assign keep     = occupied && ahead;
  assign val      = val_r;

  always_ff @(posedge clk) begin
    case (ctl.op)
      rmth_pkg::OP_POP: val_r <= next_val;
      rmth_pkg::OP_INS: begin
        if (!keep) begin
          val_r <= prev_keep ? x : prev_val;
        end
      end
      default: val_r <= val_r;
    endcase
  end

endmodule

// ===== hw/rtl/rmth_chain.sv =====
// rmth_chain: sorted row of cells with its fill count
// depends on rmth_pkg and rmth_cell; head holds the max (or min when IS_MIN)
module rmth_chain #(
  parameter int DEPTH       = 512,
  parameter int SAMPLE_BITS = 16,
  parameter bit IS_MIN      = 1'b0,
  parameter int CW          = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rmth_pkg::cell_ctl_t           ctl,
  input  logic signed [SAMPLE_BITS-1:0] x,
  output logic signed [SAMPLE_BITS-1:0] head,
  output logic [CW-1:0]                 count
);

  logic signed [SAMPLE_BITS-1:0] vals [DEPTH];
  logic                          keeps [DEPTH];
  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 count_nxt;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] pv;
    logic                          pk;
    logic signed [SAMPLE_BITS-1:0] nv;
    if (i == 0) begin : g_first
      assign pv = x;
      assign pk = 1'b1;
    end else begin : g_mid
      assign pv = vals[i-1];
      assign pk = keeps[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign nv = vals[i];
    end else begin : g_body
      assign nv = vals[i+1];
    end
    rmth_cell #(
      .IDX(i), .SAMPLE_BITS(SAMPLE_BITS), .CW(CW), .IS_MIN(IS_MIN)
    ) u_cell (
      .clk(clk), .ctl(ctl), .x(x), .count(count_r),
      .prev_val(pv), .prev_keep(pk), .next_val(nv),
      .val(vals[i]), .keep(keeps[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    case (ctl.op)
      rmth_pkg::OP_POP: count_nxt = count_r - CW'(1);
      rmth_pkg::OP_INS: count_nxt = count_r + CW'(1);
      default:          count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head  = vals[0];
  assign count = count_r;

endmodule
